// ===== src/dspd_pkg.sv =====
// dspd_pkg: shared types and constants for the differential sensor PD motor drive.
// Holds controller states, command/status structs and configuration register layout.
// No dependencies.
package dspd_pkg;

    // sample width default (top-level parameter default)
    localparam int SAMPLE_BITS_DEF = 12;

    // fixed field widths
    localparam int GAIN_W     = 15;
    localparam int DUTY_W     = 13;
    localparam int ERR_W      = 8;
    localparam int DRIVE_W    = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // error scaling: quotient magnitude stays below 100, so 7 bits
    localparam int ERR_SCALE = 100;
    localparam int QUO_BITS  = $clog2(ERR_SCALE);
    localparam int CNT_W     = $clog2(QUO_BITS);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DUTY      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOSS_THRESHOLD = 3'd4;

    // register reset values
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST      = 15'd600;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST     = 15'd3;
    localparam logic [DUTY_W-1:0] BASE_DUTY_RST      = 13'd4000;
    localparam logic [DUTY_W-1:0] DUTY_LIMIT_RST     = 13'd8000;
    localparam logic [DUTY_W-1:0] LOSS_THRESHOLD_RST = 13'd100;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] deriv_gain;
        logic [DUTY_W-1:0] base_duty;
        logic [DUTY_W-1:0] duty_limit;
        logic [DUTY_W-1:0] loss_threshold;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL_P,
        ST_MUL_D,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic mul_p;
        logic mul_d;
        logic out_load;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

// ===== src/dspd_ctrl.sv =====
// dspd_ctrl: sequencing state machine for one sample pair.
// Steps the serial divider, the shared multiplier and the output load.
// Depends on dspd_pkg.
module dspd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dspd_pkg::t_dp_stat i_stat,
    output dspd_pkg::t_dp_cmd  o_cmd
);

    dspd_pkg::t_state            r_state, n_state;
    logic [dspd_pkg::CNT_W-1:0]  r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dspd_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            dspd_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = dspd_pkg::ST_DIV;
                end
            end
            dspd_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == dspd_pkg::CNT_W'(dspd_pkg::QUO_BITS - 1)) begin
                    n_state = dspd_pkg::ST_MUL_P;
                end
            end
            dspd_pkg::ST_MUL_P: begin
                o_cmd.mul_p = 1'b1;
                n_state     = dspd_pkg::ST_MUL_D;
            end
            dspd_pkg::ST_MUL_D: begin
                o_cmd.mul_d = 1'b1;
                n_state     = dspd_pkg::ST_OUT;
            end
            dspd_pkg::ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = dspd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dspd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/dspd_datapath.sv =====
// dspd_datapath: difference/sum divider, shared PD multiplier, saturation and output register.
// Driven by dspd_ctrl commands; configuration arrives as a t_cfg struct.
// Depends on dspd_pkg.
module dspd_datapath #(
    parameter int SAMPLE_BITS = dspd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  dspd_pkg::t_dp_cmd                    i_cmd,
    output dspd_pkg::t_dp_stat                   o_stat,
    input  dspd_pkg::t_cfg                       i_cfg,
    input  logic [SAMPLE_BITS-1:0]               i_left_sample,
    input  logic [SAMPLE_BITS-1:0]               i_right_sample,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [dspd_pkg::DUTY_W-1:0]          o_motor_a_forward,
    output logic [dspd_pkg::DUTY_W-1:0]          o_motor_a_reverse,
    output logic [dspd_pkg::DUTY_W-1:0]          o_motor_b_forward,
    output logic [dspd_pkg::DUTY_W-1:0]          o_motor_b_reverse,
    output logic signed [dspd_pkg::ERR_W-1:0]    o_position_error,
    output logic signed [dspd_pkg::DRIVE_W-1:0]  o_steer_drive,
    output logic                                 o_track_lost
);

    localparam int SUM_W  = SAMPLE_BITS + 1;
    localparam int NUM_W  = SAMPLE_BITS + dspd_pkg::QUO_BITS;
    localparam int CMP_W  = (SUM_W > dspd_pkg::DUTY_W) ? SUM_W : dspd_pkg::DUTY_W;
    localparam int CMD_W  = dspd_pkg::DRIVE_W + 1;
    localparam int MA_W   = dspd_pkg::GAIN_W + 1;
    localparam int MB_W   = dspd_pkg::ERR_W + 1;
    localparam int DUTY_W = dspd_pkg::DUTY_W;
    localparam int ERR_W  = dspd_pkg::ERR_W;

    typedef struct packed {
        logic [DUTY_W-1:0] fwd;
        logic [DUTY_W-1:0] rev;
    } t_pair;

    // saturate at +/- lim, then split by sign; zero counts as forward
    function automatic t_pair sat_split(input logic signed [CMD_W-1:0] v,
                                        input logic signed [CMD_W-1:0] lim);
        logic signed [CMD_W-1:0] c;
        t_pair                   p;
        c = v;
        if (v > lim) begin
            c = lim;
        end else if (v < -lim) begin
            c = -lim;
        end
        if (c < 0) begin
            p.fwd = '0;
            p.rev = DUTY_W'(-c);
        end else begin
            p.fwd = DUTY_W'(c);
            p.rev = '0;
        end
        return p;
    endfunction

    // divider state
    logic [NUM_W-1:0]                  r_rem;
    logic [NUM_W-1:0]                  r_den;
    logic [dspd_pkg::QUO_BITS-1:0]     r_quo;
    logic                              r_neg;
    logic                              r_lost;
    // PD state
    logic signed [ERR_W-1:0]           r_err;
    logic signed [ERR_W-1:0]           r_prev;
    logic signed [dspd_pkg::DRIVE_W-1:0] r_acc;
    logic                              r_out_valid;

    logic [SAMPLE_BITS-1:0]            w_mag;
    logic [SUM_W-1:0]                  w_sum;
    logic signed [ERR_W-1:0]           w_err;
    logic signed [MA_W-1:0]            w_mul_a;
    logic signed [MB_W-1:0]            w_mul_b;
    logic signed [dspd_pkg::DRIVE_W-1:0] w_mul;
    logic signed [CMD_W-1:0]           w_base, w_drv, w_lim;
    t_pair                             w_a, w_b;

    assign w_mag = (i_left_sample >= i_right_sample) ? (i_left_sample - i_right_sample)
                                                     : (i_right_sample - i_left_sample);
    assign w_sum = SUM_W'(i_left_sample) + SUM_W'(i_right_sample);

    // signed error from quotient magnitude
    assign w_err = r_neg ? $signed(ERR_W'(0) - {1'b0, r_quo}) : $signed({1'b0, r_quo});

    // one shared multiplier: kp * err, then kd * (err - prev)
    always_comb begin
        if (i_cmd.mul_d) begin
            w_mul_a = $signed({1'b0, i_cfg.deriv_gain});
            w_mul_b = $signed({r_err[ERR_W-1], r_err}) - $signed({r_prev[ERR_W-1], r_prev});
        end else begin
            w_mul_a = $signed({1'b0, i_cfg.prop_gain});
            w_mul_b = $signed({w_err[ERR_W-1], w_err});
        end
    end
    assign w_mul = dspd_pkg::DRIVE_W'(w_mul_a) * dspd_pkg::DRIVE_W'(w_mul_b);

    assign w_base = $signed(CMD_W'(i_cfg.base_duty));
    assign w_lim  = $signed(CMD_W'(i_cfg.duty_limit));
    assign w_drv  = $signed({r_acc[dspd_pkg::DRIVE_W-1], r_acc});
    assign w_a    = sat_split(w_base + w_drv, w_lim);
    assign w_b    = sat_split(w_base - w_drv, w_lim);

    // restoring divide: den starts shifted up by QUO_BITS-1
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem  <= NUM_W'(w_mag) * NUM_W'(dspd_pkg::ERR_SCALE);
            r_den  <= NUM_W'(w_sum + 1'b1) << (dspd_pkg::QUO_BITS - 1);
            r_neg  <= i_left_sample < i_right_sample;
            r_lost <= CMP_W'(w_sum) < CMP_W'(i_cfg.loss_threshold);
            r_quo  <= '0;
        end else if (i_cmd.div_step) begin
            if (r_rem >= r_den) begin
                r_rem <= r_rem - r_den;
                r_quo <= {r_quo[dspd_pkg::QUO_BITS-2:0], 1'b1};
            end else begin
                r_quo <= {r_quo[dspd_pkg::QUO_BITS-2:0], 1'b0};
            end
            r_den <= r_den >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_p) begin
            r_err <= w_err;
            r_acc <= w_mul;
        end else if (i_cmd.mul_d) begin
            r_acc <= r_acc + w_mul;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_cmd.mul_d) begin
            r_prev <= r_err;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_position_error <= r_err;
            o_steer_drive    <= r_acc;
            o_track_lost     <= r_lost;
            if (r_lost) begin
                o_motor_a_forward <= '0;
                o_motor_a_reverse <= '0;
                o_motor_b_forward <= '0;
                o_motor_b_reverse <= '0;
            end else begin
                o_motor_a_forward <= w_a.fwd;
                o_motor_a_reverse <= w_a.rev;
                o_motor_b_forward <= w_b.fwd;
                o_motor_b_reverse <= w_b.rev;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

endmodule

// ===== src/differential_sensor_pd_motor_drive.sv =====
// differential_sensor_pd_motor_drive: top level, configuration registers and unit wiring.
// Instantiates dspd_ctrl and dspd_datapath; depends on dspd_pkg.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_left_sample, i_right_sample
//  out     | output    | o_out_valid / i_out_stall | o_motor_{a,b}_{forward,reverse},
//          |           |                           | o_position_error, o_steer_drive,
//          |           |                           | o_track_lost
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Steps per beat: accept, 7 restoring-divide steps (one quotient bit each), the shared
//   multiplier (kp*err, then kd*delta added in), then saturate and load out.
// A new beat is taken once the previous result sits in the output register, so the
//   next sample pair can enter while that result still waits to be taken.
// Stall on out holds the result; the item behind it waits in the final step.
// Reset (synchronous, active low) restores register defaults and a zero previous error.
// Config writes are always accepted; unknown indexes are dropped.
module differential_sensor_pd_motor_drive #(
    parameter int SAMPLE_BITS = dspd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [SAMPLE_BITS-1:0]                 i_left_sample,
    input  logic [SAMPLE_BITS-1:0]                 i_right_sample,
    // output channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [dspd_pkg::DUTY_W-1:0]            o_motor_a_forward,
    output logic [dspd_pkg::DUTY_W-1:0]            o_motor_a_reverse,
    output logic [dspd_pkg::DUTY_W-1:0]            o_motor_b_forward,
    output logic [dspd_pkg::DUTY_W-1:0]            o_motor_b_reverse,
    output logic signed [dspd_pkg::ERR_W-1:0]      o_position_error,
    output logic signed [dspd_pkg::DRIVE_W-1:0]    o_steer_drive,
    output logic                                   o_track_lost,
    // configuration write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [dspd_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [dspd_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    dspd_pkg::t_cfg     r_cfg;
    dspd_pkg::t_dp_cmd  w_cmd;
    dspd_pkg::t_dp_stat w_stat;

    // registers are always writable; only written while idle by contract
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain      <= dspd_pkg::PROP_GAIN_RST;
            r_cfg.deriv_gain     <= dspd_pkg::DERIV_GAIN_RST;
            r_cfg.base_duty      <= dspd_pkg::BASE_DUTY_RST;
            r_cfg.duty_limit     <= dspd_pkg::DUTY_LIMIT_RST;
            r_cfg.loss_threshold <= dspd_pkg::LOSS_THRESHOLD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                dspd_pkg::CFG_PROP_GAIN:
                    r_cfg.prop_gain <= i_cfg_data;
                dspd_pkg::CFG_DERIV_GAIN:
                    r_cfg.deriv_gain <= i_cfg_data;
                dspd_pkg::CFG_BASE_DUTY:
                    r_cfg.base_duty <= i_cfg_data[dspd_pkg::DUTY_W-1:0];
                dspd_pkg::CFG_DUTY_LIMIT:
                    r_cfg.duty_limit <= i_cfg_data[dspd_pkg::DUTY_W-1:0];
                dspd_pkg::CFG_LOSS_THRESHOLD:
                    r_cfg.loss_threshold <= i_cfg_data[dspd_pkg::DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    dspd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // divider, PD arithmetic, saturation, result register
    dspd_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_cfg             (r_cfg),
        .i_left_sample     (i_left_sample),
        .i_right_sample    (i_right_sample),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_motor_a_forward (o_motor_a_forward),
        .o_motor_a_reverse (o_motor_a_reverse),
        .o_motor_b_forward (o_motor_b_forward),
        .o_motor_b_reverse (o_motor_b_reverse),
        .o_position_error  (o_position_error),
        .o_steer_drive     (o_steer_drive),
        .o_track_lost      (o_track_lost)
    );

endmodule

// ===== test/pd_drive_checker.sv =====
// pd_drive_checker: watches the sample, result and register channels of the PD motor drive,
// predicts each result beat from its own copy of the registers and error history, compares.
// Depends on dspd_pkg.
module pd_drive_checker import dspd_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [SAMPLE_BITS-1:0]       left_sample,
    input  logic [SAMPLE_BITS-1:0]       right_sample,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [DUTY_W-1:0]            a_fwd,
    input  logic [DUTY_W-1:0]            a_rev,
    input  logic [DUTY_W-1:0]            b_fwd,
    input  logic [DUTY_W-1:0]            b_rev,
    input  logic signed [ERR_W-1:0]      pos_err,
    input  logic signed [DRIVE_W-1:0]    steer,
    input  logic                         lost,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    output int                           backlog,
    output int                           fails
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DUTY_W-1:0]         a_fwd;
        logic [DUTY_W-1:0]         a_rev;
        logic [DUTY_W-1:0]         b_fwd;
        logic [DUTY_W-1:0]         b_rev;
        logic signed [ERR_W-1:0]   err;
        logic signed [DRIVE_W-1:0] drive;
        logic                      lost;
    } t_motor_cmd;

    logic [GAIN_W-1:0]       kp;
    logic [GAIN_W-1:0]       kd;
    logic [DUTY_W-1:0]       base;
    logic [DUTY_W-1:0]       limit;
    logic [DUTY_W-1:0]       thresh;
    logic signed [ERR_W-1:0] last_err;
    t_motor_cmd              awaited_cmds[$];
    int                      mismatches = 0;

    assign fails = mismatches;

    // saturate symmetrically, then split by sign; zero counts as forward
    function automatic void split_cmd(input longint cmd, input longint lim,
                                      output logic [DUTY_W-1:0] fwd,
                                      output logic [DUTY_W-1:0] rev);
        longint sat;
        sat = (cmd > lim) ? lim : ((cmd < -lim) ? -lim : cmd);
        if (sat < 0) begin
            fwd = '0;
            rev = DUTY_W'(-sat);
        end else begin
            fwd = DUTY_W'(sat);
            rev = '0;
        end
    endfunction

    function automatic t_motor_cmd predict_motor_cmd(input longint l, input longint r);
        longint     sum;
        longint     err;
        longint     drv;
        t_motor_cmd c;
        sum = l + r;
        err = ((l - r) * ERR_SCALE) / (sum + 1);   // truncates toward zero
        drv = longint'(kp) * err + longint'(kd) * (err - longint'(last_err));
        c = '0;
        c.err   = err[ERR_W-1:0];
        c.drive = drv[DRIVE_W-1:0];
        c.lost  = (sum < longint'(thresh));
        if (!c.lost) begin
            split_cmd(longint'(base) + drv, longint'(limit), c.a_fwd, c.a_rev);
            split_cmd(longint'(base) - drv, longint'(limit), c.b_fwd, c.b_rev);
        end
        return c;
    endfunction

    function automatic void compare_field(input string tag, input longint want,
                                          input longint got);
        if (want != got) begin
            mismatches++;
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, tag, want, got);
        end
    endfunction

    always @(posedge clk) begin : watch
        t_motor_cmd want;
        if (!rst_n) begin
            kp       = PROP_GAIN_RST;
            kd       = DERIV_GAIN_RST;
            base     = BASE_DUTY_RST;
            limit    = DUTY_LIMIT_RST;
            thresh   = LOSS_THRESHOLD_RST;
            last_err = '0;
            awaited_cmds.delete();
        end else begin
            if (out_valid && !out_stall) begin
                if (awaited_cmds.size() == 0) begin
                    mismatches++;
                    $display("%0t unexpected result beat: expected none, actual err %0d drive %0d",
                             $time, pos_err, steer);
                end else begin
                    want = awaited_cmds.pop_front();
                    compare_field("motor_a_forward", longint'(want.a_fwd), longint'(a_fwd));
                    compare_field("motor_a_reverse", longint'(want.a_rev), longint'(a_rev));
                    compare_field("motor_b_forward", longint'(want.b_fwd), longint'(b_fwd));
                    compare_field("motor_b_reverse", longint'(want.b_rev), longint'(b_rev));
                    compare_field("position_error", longint'(want.err), longint'(pos_err));
                    compare_field("steer_drive", longint'(want.drive), longint'(steer));
                    compare_field("track_lost", longint'(want.lost), longint'(lost));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PROP_GAIN:      kp = cfg_data[GAIN_W-1:0];
                    CFG_DERIV_GAIN:     kd = cfg_data[GAIN_W-1:0];
                    CFG_BASE_DUTY:      base = cfg_data[DUTY_W-1:0];
                    CFG_DUTY_LIMIT:     limit = cfg_data[DUTY_W-1:0];
                    CFG_LOSS_THRESHOLD: thresh = cfg_data[DUTY_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall) begin
                want = predict_motor_cmd(longint'(left_sample), longint'(right_sample));
                last_err = want.err;
                awaited_cmds.push_back(want);
            end
        end
        backlog <= awaited_cmds.size();
    end

endmodule

// ===== test/tb.sv =====
// tb: stimulus and verdict for differential_sensor_pd_motor_drive.
// Drives sample beats, register writes and result stalls; pd_drive_checker does the checking.
// Depends on dspd_pkg, differential_sensor_pd_motor_drive and pd_drive_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dspd_pkg::*;

    localparam int SW = SAMPLE_BITS_DEF;
    localparam logic [SW-1:0] SAMPLE_MAX = '1;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [SW-1:0]             i_left_sample = '0;
    logic [SW-1:0]             i_right_sample = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [DUTY_W-1:0]         o_motor_a_forward;
    logic [DUTY_W-1:0]         o_motor_a_reverse;
    logic [DUTY_W-1:0]         o_motor_b_forward;
    logic [DUTY_W-1:0]         o_motor_b_reverse;
    logic signed [ERR_W-1:0]   o_position_error;
    logic signed [DRIVE_W-1:0] o_steer_drive;
    logic                      o_track_lost;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = CFG_PROP_GAIN;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;

    int backlog;
    int fails;
    bit calm = 1'b0;    // set for the closing phase: no gaps, no stalls

    always #5 i_clk = ~i_clk;

    differential_sensor_pd_motor_drive #(.SAMPLE_BITS(SW)) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_left_sample     (i_left_sample),
        .i_right_sample    (i_right_sample),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_motor_a_forward (o_motor_a_forward),
        .o_motor_a_reverse (o_motor_a_reverse),
        .o_motor_b_forward (o_motor_b_forward),
        .o_motor_b_reverse (o_motor_b_reverse),
        .o_position_error  (o_position_error),
        .o_steer_drive     (o_steer_drive),
        .o_track_lost      (o_track_lost),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    pd_drive_checker #(.SAMPLE_BITS(SW)) u_check (
        .clk          (i_clk),
        .rst_n        (i_rst_n),
        .in_valid     (i_in_valid),
        .in_stall     (o_in_stall),
        .left_sample  (i_left_sample),
        .right_sample (i_right_sample),
        .out_valid    (o_out_valid),
        .out_stall    (i_out_stall),
        .a_fwd        (o_motor_a_forward),
        .a_rev        (o_motor_a_reverse),
        .b_fwd        (o_motor_b_forward),
        .b_rev        (o_motor_b_reverse),
        .pos_err      (o_position_error),
        .steer        (o_steer_drive),
        .lost         (o_track_lost),
        .cfg_valid    (i_cfg_valid),
        .cfg_ready    (o_cfg_ready),
        .cfg_index    (i_cfg_index),
        .cfg_data     (i_cfg_data),
        .backlog      (backlog),
        .fails        (fails)
    );

    // One sample beat. Valid is left high on return so back-to-back beats never lower
    // and raise it in the same step; a gap, when drawn, lowers it afterwards.
    task automatic offer_pair(input logic [SW-1:0] l, input logic [SW-1:0] r);
        i_in_valid     <= 1'b1;
        i_left_sample  <= l;
        i_right_sample <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    // Quiesce: stop offering, wait for every predicted result, then let the sequencer
    // settle so the block is truly idle before any register write.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (backlog != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // Single register beat; valid stays up for a following write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // All five registers, plus a write to an unused index that must change nothing.
    task automatic program_regs(input logic [CFG_DATA_W-1:0] kp, input logic [CFG_DATA_W-1:0] kd,
                                input logic [CFG_DATA_W-1:0] base,
                                input logic [CFG_DATA_W-1:0] lim,
                                input logic [CFG_DATA_W-1:0] thr);
        write_reg(CFG_PROP_GAIN, kp);
        write_reg(CFG_DERIV_GAIN, kd);
        write_reg(CFG_BASE_DUTY, base);
        write_reg(CFG_DUTY_LIMIT, lim);
        write_reg(CFG_LOSS_THRESHOLD, thr);
        write_reg(CFG_IDX_W'($urandom_range(int'(CFG_LOSS_THRESHOLD) + 1, (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // Register value: zero, the field maximum, anything, or a usual working value.
    // For 13-bit registers the two spare data bits are sometimes set; they must be dropped.
    function automatic logic [CFG_DATA_W-1:0] pick_setting(input int unsigned top,
                                                            input int unsigned usual,
                                                            input bit narrow);
        logic [CFG_DATA_W-1:0] v;
        case ($urandom_range(0, 4))
            0:       v = '0;
            1:       v = CFG_DATA_W'(top);
            2:       v = CFG_DATA_W'($urandom_range(0, top));
            default: v = CFG_DATA_W'($urandom_range(0, usual));
        endcase
        if (narrow && $urandom_range(0, 3) == 0)
            v[CFG_DATA_W-1:DUTY_W] = (CFG_DATA_W - DUTY_W)'($urandom_range(1, 3));
        return v;
    endfunction

    // Sample pair: mostly on-track readings with random content, plus the edges
    // of the range, balanced pairs and readings around the loss threshold.
    task automatic offer_random_pair();
        logic [SW-1:0] l;
        logic [SW-1:0] r;
        l = SW'($urandom);
        r = SW'($urandom);
        case ($urandom_range(0, 9))
            5: begin
                l = SW'($urandom_range(0, 255));
                r = SW'($urandom_range(0, 255));
            end
            6: r = l;
            7: begin
                l = $urandom_range(0, 1) ? SAMPLE_MAX : '0;
                r = $urandom_range(0, 1) ? SAMPLE_MAX : '0;
            end
            8: r = (l > 40) ? l - SW'($urandom_range(0, 40)) : l + SW'($urandom_range(0, 40));
            9: if ($urandom_range(0, 1)) l = '0; else r = '0;
            default: ;
        endcase
        offer_pair(l, r);
    endtask

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset register values (threshold 100)
        offer_pair('0, '0);                 // nothing seen: lost, zero error
        offer_pair(SAMPLE_MAX, SAMPLE_MAX); // balanced at full scale
        offer_pair(SAMPLE_MAX, '0);         // hard left, both commands saturate
        offer_pair('0, SAMPLE_MAX);         // hard right, derivative swings the other way
        offer_pair(SW'(1), '0);
        offer_pair('0, SW'(1));
        offer_pair(SW'(50), SW'(49));       // sum one below threshold: lost
        offer_pair(SW'(50), SW'(50));       // sum at threshold: driven
        offer_pair(SW'(60), SW'(40));
        offer_pair(SW'(40), SW'(60));       // negative quotient truncates toward zero
        offer_pair(SW'(12'hAAA), SW'(12'h555));
        offer_pair(SW'(12'h555), SW'(12'hAAA));
        offer_pair(SW'(2048), SW'(2047));
        drain_results();

        // no gain and no base: exactly zero command on both motors
        program_regs('0, '0, '0, CFG_DATA_W'(DUTY_LIMIT_RST), CFG_DATA_W'(LOSS_THRESHOLD_RST));
        offer_pair(SW'(1000), SW'(1000));
        offer_pair(SW'(3000), SW'(1000));
        offer_pair(SW'(200), SW'(900));
        drain_results();

        // every register at its top, threshold zero so nothing is ever lost
        program_regs('1, '1, CFG_DATA_W'(8191), CFG_DATA_W'(8191), '0);
        offer_pair(SAMPLE_MAX, '0);
        offer_pair('0, SAMPLE_MAX);
        offer_pair('0, '0);
        offer_pair(SAMPLE_MAX, SAMPLE_MAX);
        offer_pair(SW'(7), SW'(3));
        drain_results();

        // random phases, fresh register settings each time; the last one runs calm
        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 9) calm <= 1'b1;
            program_regs(pick_setting(32767, 1000, 1'b0), pick_setting(32767, 200, 1'b0),
                         pick_setting(8191, 6000, 1'b1), pick_setting(8191, 8191, 1'b1),
                         pick_setting(8191, 400, 1'b1));
            repeat (124) offer_random_pair();
            drain_results();
        end

        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // result-side back-pressure: stall bursts between free stretches, some of them long
    initial begin : stall_gen
        repeat (8) @(posedge i_clk);
        forever begin
            if (calm) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_out_stall <= 1'b0;
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(50, 150)) @(posedge i_clk);
                else
                    repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    // hang guard
    initial begin : watchdog
        #5ms;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/dspd_pkg.sv
src/dspd_ctrl.sv
src/dspd_datapath.sv
src/differential_sensor_pd_motor_drive.sv
test/pd_drive_checker.sv
test/tb.sv
